### rtl/core/assert_macros.svh
// assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// concurrent check sampled on the rising clock, off while in reset
`define LCM_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error(msg);

// antecedent in one cycle, consequent in the next
`define LCM_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    `LCM_ASSERT(label, clk, rst_n, (ante) |=> (cons), msg)

`endif

### rtl/core/lcm_pkg.sv
package lcm_pkg;

    // default operand width and fixed port widths
    localparam int unsigned OPERAND_WIDTH_DEF = 32;
    localparam int unsigned IN_W              = 32;
    localparam int unsigned LCM_W             = 64;
    localparam int unsigned GCD_W             = 32;

    // controller states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_GCD,
        ST_DIV,
        ST_MUL,
        ST_DONE
    } state_t;

    // datapath operations
    typedef enum logic [2:0] {
        OP_NONE,
        OP_LOAD,
        OP_GCD,
        OP_DIV,
        OP_MUL,
        OP_OUT
    } op_t;

    // controller to datapath
    typedef struct packed {
        op_t op;
    } dp_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic gcd_done;
        logic zero_op;
    } dp_status_t;

endpackage

### rtl/core/lcm_datapath.sv
module lcm_datapath #(
    parameter int unsigned OPERAND_WIDTH = lcm_pkg::OPERAND_WIDTH_DEF
) (
    input  logic                       clk,
    input  lcm_pkg::dp_cmd_t           cmd,
    output lcm_pkg::dp_status_t        status,
    input  logic [lcm_pkg::IN_W-1:0]   operand_a,
    input  logic [lcm_pkg::IN_W-1:0]   operand_b,
    output logic [lcm_pkg::LCM_W-1:0]  lcm_value,
    output logic [lcm_pkg::GCD_W-1:0]  gcd_value,
    output logic                       zero_operand
);
    import lcm_pkg::*;

    localparam int unsigned W  = OPERAND_WIDTH;
    localparam int unsigned KW = (W > 1) ? $clog2(W) : 1;

    logic [W-1:0]     a_reg, a_next;
    logic [W-1:0]     x_reg, x_next;
    logic [W-1:0]     y_reg, y_next;
    logic [W-1:0]     g_reg, g_next;
    logic [W-1:0]     rem_reg, rem_next;
    logic [KW-1:0]    k_reg, k_next;
    logic [2*W-1:0]   mcand_reg, mcand_next;
    logic [2*W-1:0]   prod_reg, prod_next;
    logic             zero_reg, zero_next;
    logic [LCM_W-1:0] lcm_out_reg, lcm_out_next;
    logic [GCD_W-1:0] gcd_out_reg, gcd_out_next;
    logic             zero_out_reg, zero_out_next;

    logic [W-1:0]     op_a;
    logic [W-1:0]     op_b;
    logic [W-1:0]     diff_xy;
    logic [W-1:0]     diff_yx;
    logic [W:0]       trial;
    logic [W:0]       trial_sub;
    logic             q_bit;
    logic             xy_zero;

    // masked operands
    assign op_a = operand_a[W-1:0];
    assign op_b = operand_b[W-1:0];

    // shared arithmetic
    assign diff_xy   = x_reg - y_reg;
    assign diff_yx   = y_reg - x_reg;
    assign trial     = {rem_reg, x_reg[W-1]};
    assign trial_sub = trial - {1'b0, g_reg};
    assign q_bit     = ~trial_sub[W];
    assign xy_zero   = (x_reg == '0) || (y_reg == '0);

    assign status.gcd_done = xy_zero;
    assign status.zero_op  = zero_reg;

    // next values per operation
    always_comb
    begin
        a_next        = a_reg;
        x_next        = x_reg;
        y_next        = y_reg;
        g_next        = g_reg;
        rem_next      = rem_reg;
        k_next        = k_reg;
        mcand_next    = mcand_reg;
        prod_next     = prod_reg;
        zero_next     = zero_reg;
        lcm_out_next  = lcm_out_reg;
        gcd_out_next  = gcd_out_reg;
        zero_out_next = zero_out_reg;
        case (cmd.op)
            OP_LOAD:
            begin
                a_next     = op_a;
                x_next     = op_a;
                y_next     = op_b;
                k_next     = '0;
                mcand_next = {{W{1'b0}}, op_b};
                prod_next  = '0;
                zero_next  = (op_a == '0) || (op_b == '0);
            end
            OP_GCD:
            begin
                // binary gcd, one reduction per cycle
                if (xy_zero)
                begin
                    g_next   = (x_reg | y_reg) << k_reg;
                    x_next   = a_reg;
                    rem_next = '0;
                end
                else if (!x_reg[0] && !y_reg[0])
                begin
                    x_next = x_reg >> 1;
                    y_next = y_reg >> 1;
                    k_next = k_reg + KW'(1);
                end
                else if (!x_reg[0])
                begin
                    x_next = x_reg >> 1;
                end
                else if (!y_reg[0])
                begin
                    y_next = y_reg >> 1;
                end
                else if (x_reg >= y_reg)
                begin
                    x_next = diff_xy >> 1;
                end
                else
                begin
                    y_next = diff_yx >> 1;
                end
            end
            OP_DIV:
            begin
                // restoring division, quotient shifts into x
                x_next   = {x_reg[W-2:0], q_bit};
                rem_next = q_bit ? trial_sub[W-1:0] : trial[W-1:0];
            end
            OP_MUL:
            begin
                // shift-add multiply of quotient by b
                if (x_reg[0])
                begin
                    prod_next = prod_reg + mcand_reg;
                end
                mcand_next = mcand_reg << 1;
                x_next     = x_reg >> 1;
            end
            OP_OUT:
            begin
                lcm_out_next  = LCM_W'(prod_reg);
                gcd_out_next  = GCD_W'(g_reg);
                zero_out_next = zero_reg;
            end
            default:
            begin
            end
        endcase
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        a_reg        <= a_next;
        x_reg        <= x_next;
        y_reg        <= y_next;
        g_reg        <= g_next;
        rem_reg      <= rem_next;
        k_reg        <= k_next;
        mcand_reg    <= mcand_next;
        prod_reg     <= prod_next;
        zero_reg     <= zero_next;
        lcm_out_reg  <= lcm_out_next;
        gcd_out_reg  <= gcd_out_next;
        zero_out_reg <= zero_out_next;
    end

    assign lcm_value    = lcm_out_reg;
    assign gcd_value    = gcd_out_reg;
    assign zero_operand = zero_out_reg;

endmodule

### rtl/core/lcm_ctrl.sv
module lcm_ctrl #(
    parameter int unsigned OPERAND_WIDTH = lcm_pkg::OPERAND_WIDTH_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_stall,
    output logic                out_valid,
    input  logic                out_stall,
    output lcm_pkg::dp_cmd_t    cmd,
    input  lcm_pkg::dp_status_t status
);
    import lcm_pkg::*;

    localparam int unsigned KW = (OPERAND_WIDTH > 1) ? $clog2(OPERAND_WIDTH) : 1;

    state_t        state_reg, state_next;
    logic [KW-1:0] cnt_reg, cnt_next;
    logic          out_valid_reg, out_valid_next;

    // state and counter registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // next state and datapath command
    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        cmd.op     = OP_NONE;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.op     = OP_LOAD;
                    state_next = ST_GCD;
                end
            end
            ST_GCD:
            begin
                cmd.op = OP_GCD;
                if (status.gcd_done)
                begin
                    state_next = status.zero_op ? ST_DONE : ST_DIV;
                    cnt_next   = KW'(OPERAND_WIDTH - 1);
                end
            end
            ST_DIV:
            begin
                cmd.op = OP_DIV;
                if (cnt_reg == '0)
                begin
                    state_next = ST_MUL;
                    cnt_next   = KW'(OPERAND_WIDTH - 1);
                end
                else
                begin
                    cnt_next = cnt_reg - KW'(1);
                end
            end
            ST_MUL:
            begin
                cmd.op = OP_MUL;
                if (cnt_reg == '0)
                begin
                    state_next = ST_DONE;
                end
                else
                begin
                    cnt_next = cnt_reg - KW'(1);
                end
            end
            ST_DONE:
            begin
                // wait for the output register to be free
                if (!out_valid_reg || !out_stall)
                begin
                    cmd.op     = OP_OUT;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // output valid: set on load of a result, cleared on transfer
    always_comb
    begin
        if (cmd.op == OP_OUT)
        begin
            out_valid_next = 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    assign in_stall  = (state_reg != ST_IDLE);
    assign out_valid = out_valid_reg;

endmodule

### rtl/core/lcm_via_euclid_gcd.sv
// channel  | handshake                   | payload
// ---------+-----------------------------+------------------------------------
// input    | in_valid / in_stall         | operand_a, operand_b
// output   | out_valid / out_stall       | lcm_value, gcd_value, zero_operand
//
// one item at a time: a load, then binary gcd reduction, restoring divide,
// shift-add multiply and a load of the output register; a zero operand skips
// divide and multiply
// the gcd, divide and multiply all run on one shared set of datapath registers
// asynchronous active-low reset clears the controller and output valid only
// a held output stalls the finished item in its last state; the input stays
// stalled until that result has gone into the output register
module lcm_via_euclid_gcd #(
    parameter int unsigned OPERAND_WIDTH = lcm_pkg::OPERAND_WIDTH_DEF
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       in_valid,
    output logic                       in_stall,
    input  logic [lcm_pkg::IN_W-1:0]   operand_a,
    input  logic [lcm_pkg::IN_W-1:0]   operand_b,
    output logic                       out_valid,
    input  logic                       out_stall,
    output logic [lcm_pkg::LCM_W-1:0]  lcm_value,
    output logic [lcm_pkg::GCD_W-1:0]  gcd_value,
    output logic                       zero_operand
);
    import lcm_pkg::*;

    dp_cmd_t    cmd;
    dp_status_t status;

    // sequencer
    lcm_ctrl #(
        .OPERAND_WIDTH (OPERAND_WIDTH)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .cmd       (cmd),
        .status    (status)
    );

    // shared arithmetic and result register
    lcm_datapath #(
        .OPERAND_WIDTH (OPERAND_WIDTH)
    ) u_datapath (
        .clk          (clk),
        .cmd          (cmd),
        .status       (status),
        .operand_a    (operand_a),
        .operand_b    (operand_b),
        .lcm_value    (lcm_value),
        .gcd_value    (gcd_value),
        .zero_operand (zero_operand)
    );

endmodule

### rtl/core/lcm_checker.sv
`include "assert_macros.svh"

module lcm_checker (
    input logic                      clk,
    input logic                      rst_n,
    input logic                      in_valid,
    input logic                      in_stall,
    input logic                      out_valid,
    input logic                      out_stall,
    input logic [lcm_pkg::LCM_W-1:0] lcm_value,
    input logic [lcm_pkg::GCD_W-1:0] gcd_value,
    input logic                      zero_operand
);

    // a transfer in makes the block busy on the next cycle
    `LCM_ASSERT_NEXT(a_busy_after_in, clk, rst_n, in_valid && !in_stall, in_stall,
        "input accepted but block not busy")

    // zero flag implies a zero lcm
    `LCM_ASSERT(a_zero_lcm, clk, rst_n,
        (out_valid && zero_operand) |-> (lcm_value == '0),
        "zero operand with nonzero lcm")

    // nonzero operands give a nonzero gcd and lcm
    `LCM_ASSERT(a_nonzero, clk, rst_n,
        (out_valid && !zero_operand) |-> ((gcd_value != '0) && (lcm_value != '0)),
        "nonzero operands with zero result")

    // a held result stays offered
    `LCM_ASSERT_NEXT(a_valid_hold, clk, rst_n, out_valid && out_stall, out_valid,
        "output valid dropped while stalled")

    // a held result does not change
    `LCM_ASSERT_NEXT(a_data_hold, clk, rst_n, out_valid && out_stall,
        $stable(lcm_value) && $stable(gcd_value) && $stable(zero_operand),
        "output changed while stalled")

endmodule

bind lcm_via_euclid_gcd lcm_checker u_lcm_checker (.*);

### dv/lcm_checker.sv
// watches both channels, predicts gcd and lcm per input transfer and compares
module lcm_scoreboard #(
    parameter int unsigned OPERAND_WIDTH = lcm_pkg::OPERAND_WIDTH_DEF
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       in_valid,
    input  logic                       in_stall,
    input  logic [lcm_pkg::IN_W-1:0]   operand_a,
    input  logic [lcm_pkg::IN_W-1:0]   operand_b,
    input  logic                       out_valid,
    input  logic                       out_stall,
    input  logic [lcm_pkg::LCM_W-1:0]  lcm_value,
    input  logic [lcm_pkg::GCD_W-1:0]  gcd_value,
    input  logic                       zero_operand,
    output int                         fault_count,
    output int                         outstanding
);

    import lcm_pkg::*;

    typedef struct packed {
        logic [LCM_W-1:0] lcm;
        logic [GCD_W-1:0] gcd;
        logic             zero;
    } lcm_gcd_t;

    // results owed by the block, oldest first
    lcm_gcd_t lcm_gcd_due[$];
    int       faults    = 0;
    int       due_count = 0;

    assign fault_count = faults;
    assign outstanding = due_count;

    // euclid on masked operands, lcm as (a / gcd) * b at 64 bits
    function automatic lcm_gcd_t lcm_gcd_of(logic [IN_W-1:0] a_in, logic [IN_W-1:0] b_in);
        logic [63:0] mask;
        logic [63:0] a;
        logic [63:0] b;
        logic [63:0] x;
        logic [63:0] y;
        logic [63:0] r;
        lcm_gcd_t    res;
        mask = (64'd1 << OPERAND_WIDTH) - 64'd1;
        a = 64'(a_in) & mask;
        b = 64'(b_in) & mask;
        if (a == 64'd0 || b == 64'd0)
        begin
            // a zero operand: gcd is the other one, no division
            res.gcd  = (a == 64'd0) ? b[GCD_W-1:0] : a[GCD_W-1:0];
            res.lcm  = '0;
            res.zero = 1'b1;
        end
        else
        begin
            x = a;
            y = b;
            while (y != 64'd0)
            begin
                r = x % y;
                x = y;
                y = r;
            end
            res.gcd  = x[GCD_W-1:0];
            res.lcm  = (a / x) * b;
            res.zero = 1'b0;
        end
        return res;
    endfunction

    // sample both channels at the rising edge
    always @(posedge clk)
    begin
        lcm_gcd_t want;
        if (rst_n)
        begin
            if (in_valid && !in_stall)
                lcm_gcd_due.push_back(lcm_gcd_of(operand_a, operand_b));
            if (out_valid && !out_stall)
            begin
                if (lcm_gcd_due.size() == 0)
                begin
                    $error("result transfer with nothing due: lcm_value %0h gcd_value %0h",
                           lcm_value, gcd_value);
                    faults++;
                end
                else
                begin
                    want = lcm_gcd_due.pop_front();
                    if (lcm_value !== want.lcm)
                    begin
                        $error("lcm_value: expected %0h, actual %0h", want.lcm, lcm_value);
                        faults++;
                    end
                    if (gcd_value !== want.gcd)
                    begin
                        $error("gcd_value: expected %0h, actual %0h", want.gcd, gcd_value);
                        faults++;
                    end
                    if (zero_operand !== want.zero)
                    begin
                        $error("zero_operand: expected %0b, actual %0b",
                               want.zero, zero_operand);
                        faults++;
                    end
                end
            end
            due_count = lcm_gcd_due.size();
        end
    end

endmodule

### dv/testbench.sv
module testbench;

    import lcm_pkg::*;

    localparam int CYCLE_LIMIT  = 1000000;
    localparam int RANDOM_ITEMS = 850;
    localparam int CHUNKS       = 8;
    localparam int TAIL_CYCLES  = 140;

    typedef enum int {
        PACE_FREE,
        PACE_SENDER_IDLE,
        PACE_RECEIVER_STALL,
        PACE_BOTH
    } pace_t;

    logic              clk       = 1'b0;
    logic              rst_n     = 1'b0;
    logic              in_valid  = 1'b0;
    logic              in_stall;
    logic [IN_W-1:0]   operand_a = '0;
    logic [IN_W-1:0]   operand_b = '0;
    logic              out_valid;
    logic              out_stall = 1'b0;
    logic [LCM_W-1:0]  lcm_value;
    logic [GCD_W-1:0]  gcd_value;
    logic              zero_operand;
    int                fault_count;
    int                outstanding;
    int                cycle_count = 0;
    pace_t             pace = PACE_FREE;

    lcm_via_euclid_gcd dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .operand_a    (operand_a),
        .operand_b    (operand_b),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .lcm_value    (lcm_value),
        .gcd_value    (gcd_value),
        .zero_operand (zero_operand)
    );

    lcm_scoreboard u_scoreboard (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .operand_a    (operand_a),
        .operand_b    (operand_b),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .lcm_value    (lcm_value),
        .gcd_value    (gcd_value),
        .zero_operand (zero_operand),
        .fault_count  (fault_count),
        .outstanding  (outstanding)
    );

    // clock
    initial
    begin
        forever #10 clk = ~clk;
    end

    // run guard
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("testbench: errors");
            $finish;
        end
    end

    // receiver stalls according to the current pace
    always @(negedge clk)
    begin
        case (pace)
            PACE_RECEIVER_STALL: out_stall <= ($urandom_range(0, 99) < 75);
            PACE_BOTH:           out_stall <= ($urandom_range(0, 99) < 18);
            default:             out_stall <= 1'b0;
        endcase
    end

    function automatic bit sender_idles();
        case (pace)
            PACE_SENDER_IDLE: return $urandom_range(0, 99) < 75;
            PACE_BOTH:        return $urandom_range(0, 99) < 18;
            default:          return 1'b0;
        endcase
    endfunction

    // one input transfer, entered and left at a falling edge
    task automatic send_operands(input logic [IN_W-1:0] a, input logic [IN_W-1:0] b);
        while (sender_idles())
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid  <= 1'b1;
        operand_a <= a;
        operand_b <= b;
        do
            @(posedge clk);
        while (in_stall);
        @(negedge clk);
    endtask

    // operand pairs: wide random, small, shared factors, zeros, edges
    task automatic random_pair(output logic [IN_W-1:0] a, output logic [IN_W-1:0] b);
        logic [IN_W-1:0] g;
        case ($urandom_range(0, 9))
            0, 1, 2:
            begin
                a = $urandom();
                b = $urandom();
            end
            3:
            begin
                a = $urandom_range(0, 255);
                b = $urandom_range(0, 255);
            end
            4, 5:
            begin
                // common factor so the gcd is large
                g = $urandom_range(1, 65535);
                a = g * $urandom_range(1, 65535);
                b = g * $urandom_range(1, 65535);
            end
            6:
            begin
                a = ($urandom_range(0, 1) != 0) ? '0 : $urandom();
                b = (a != 0) ? '0 : $urandom();
            end
            7:
            begin
                a = 32'd1 << $urandom_range(0, 31);
                b = $urandom() >> $urandom_range(0, 31);
            end
            8:
            begin
                a = $urandom();
                b = a;
            end
            default:
            begin
                a = 32'hFFFF_FFFF - $urandom_range(0, 15);
                b = $urandom();
            end
        endcase
    endtask

    // stimulus and verdict
    initial
    begin
        logic [IN_W-1:0] a;
        logic [IN_W-1:0] b;
        repeat (12) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // directed: zeros, ones, extremes, equal, coprime, long euclid chains
        send_operands(32'd0, 32'd0);
        send_operands(32'd0, 32'd5);
        send_operands(32'd7, 32'd0);
        send_operands(32'd0, 32'hFFFF_FFFF);
        send_operands(32'hFFFF_FFFF, 32'd0);
        send_operands(32'd1, 32'd1);
        send_operands(32'd1, 32'hFFFF_FFFF);
        send_operands(32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_operands(32'hFFFF_FFFF, 32'hFFFF_FFFE);
        send_operands(32'd12, 32'd18);
        send_operands(32'd18, 32'd12);
        send_operands(32'd6, 32'd35);
        send_operands(32'd17, 32'd17);
        send_operands(32'h8000_0000, 32'h8000_0000);
        send_operands(32'h8000_0000, 32'd1);
        send_operands(32'h8000_0000, 32'd3);
        send_operands(32'hFFFF_0000, 32'h0000_FFFF);
        send_operands(32'hAAAA_AAAA, 32'h5555_5555);
        send_operands(32'd4294967291, 32'd4294967279);
        send_operands(32'd2971215073, 32'd1836311903);
        send_operands(32'd1836311903, 32'd2971215073);
        send_operands(32'd1000000007, 32'd998244353);

        // random, cycling through the pacing modes
        for (int chunk = 0; chunk < CHUNKS; chunk++)
        begin
            pace = pace_t'(chunk % 4);
            for (int i = 0; i < RANDOM_ITEMS / CHUNKS; i++)
            begin
                random_pair(a, b);
                send_operands(a, b);
            end
        end
        in_valid <= 1'b0;

        // drain
        wait (outstanding == 0);
        repeat (TAIL_CYCLES) @(posedge clk);
        if (fault_count == 0)
            $display("testbench: clean");
        else
            $display("testbench: errors");
        $finish;
    end

endmodule
